### sv/esdate_pkg.sv
package esdate_pkg;

   localparam logic [11:0] FirstYear      = 12'd1970;
   localparam logic [3:0]  FirstMonth     = 4'd1;
   localparam logic [3:0]  LastMonth      = 4'd12;
   localparam logic [31:0] SecsCommonYear = 32'd31536000;
   localparam logic [31:0] SecsLeapYear   = 32'd31622400;
   localparam logic [16:0] SecsPerDay     = 17'd86400;
   localparam logic [11:0] SecsPerHour    = 12'd3600;
   localparam logic [5:0]  SecsPerMinute  = 6'd60;

   // reciprocals: day = (rest >> 7) * DayRecip >> 24, exact below 31 days
   localparam logic [14:0] DayRecip  = 15'd24856;
   // hour = (rest >> 4) * HourRecip >> 20, exact below one day
   localparam logic [12:0] HourRecip = 13'd4661;
   // minute = rest * MinRecip >> 20, exact below one hour
   localparam logic [14:0] MinRecip  = 15'd17477;

   typedef struct packed {
      logic load;
      logic year_step;
      logic month_step;
      logic day_q;
      logic day_r;
      logic hour_q;
      logic hour_r;
      logic min_q;
      logic min_r;
   } cmd_type;

   typedef struct packed {
      logic year_done;
      logic month_done;
   } status_type;

   // length of a month in seconds
   function automatic logic [21:0] month_secs(input logic leap, input logic [3:0] month);
      logic [4:0] days;
      unique case (month) inside
         4'd2:                      days = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   days = 5'd30;
         default:                   days = 5'd31;
      endcase
      return 22'(days) * 22'(SecsPerDay);
   endfunction

endpackage

### sv/epoch_seconds_to_calendar_date_core.sv
// channel   ports                                  handshake
// request   req_epoch_seconds                      start, taken when busy is low
// response  rsp_year, rsp_month, rsp_day,          rsp_strobe, one cycle, no stall
//           rsp_hour, rsp_minute, rsp_second
//
// one transaction at a time: after the accepting edge a year loop (one year a
// cycle) and then a month loop (one month a cycle) run, then the day, hour and
// minute steps, and then the result strobe.
// day, hour and minute each take a reciprocal multiply and a remainder step
// reset is synchronous and active high, returns the controller to idle
// busy stays high through the strobe cycle; the receiver cannot stall results
module epoch_seconds_to_calendar_date_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_epoch_seconds,
   output logic        rsp_strobe,
   output logic [11:0] rsp_year,
   output logic [3:0]  rsp_month,
   output logic [4:0]  rsp_day,
   output logic [4:0]  rsp_hour,
   output logic [5:0]  rsp_minute,
   output logic [5:0]  rsp_second
);

   esdate_pkg::cmd_type    cmd;
   esdate_pkg::status_type status;

   esdate_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   esdate_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_epoch_seconds (req_epoch_seconds),
      .status            (status),
      .rsp_year          (rsp_year),
      .rsp_month         (rsp_month),
      .rsp_day           (rsp_day),
      .rsp_hour          (rsp_hour),
      .rsp_minute        (rsp_minute),
      .rsp_second        (rsp_second)
   );

endmodule

### sv/esdate_ctrl.sv
module esdate_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  esdate_pkg::status_type status,
   output esdate_pkg::cmd_type    cmd,
   output logic                   busy,
   output logic                   rsp_strobe
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_YEAR   = 4'd1;
   localparam logic [3:0] S_MONTH  = 4'd2;
   localparam logic [3:0] S_DAY_Q  = 4'd3;
   localparam logic [3:0] S_DAY_R  = 4'd4;
   localparam logic [3:0] S_HOUR_Q = 4'd5;
   localparam logic [3:0] S_HOUR_R = 4'd6;
   localparam logic [3:0] S_MIN_Q  = 4'd7;
   localparam logic [3:0] S_MIN_R  = 4'd8;
   localparam logic [3:0] S_DONE   = 4'd9;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_YEAR;
            end
         end
         S_YEAR: begin
            if (status.year_done) begin
               state_in = S_MONTH;
            end else begin
               cmd.year_step = 1'b1;
            end
         end
         S_MONTH: begin
            if (status.month_done) begin
               state_in = S_DAY_Q;
            end else begin
               cmd.month_step = 1'b1;
            end
         end
         S_DAY_Q: begin
            cmd.day_q = 1'b1;
            state_in  = S_DAY_R;
         end
         S_DAY_R: begin
            cmd.day_r = 1'b1;
            state_in  = S_HOUR_Q;
         end
         S_HOUR_Q: begin
            cmd.hour_q = 1'b1;
            state_in   = S_HOUR_R;
         end
         S_HOUR_R: begin
            cmd.hour_r = 1'b1;
            state_in   = S_MIN_Q;
         end
         S_MIN_Q: begin
            cmd.min_q = 1'b1;
            state_in  = S_MIN_R;
         end
         S_MIN_R: begin
            cmd.min_r = 1'b1;
            state_in  = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = (state_ff == S_DONE);

   // result strobe lasts one cycle and frees the block
   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |=> (state_ff == S_IDLE))
      else $error("result strobe not followed by idle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_strobe))
      else $error("accepted transaction did not start work");

   a_single_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command at once");

endmodule

### sv/esdate_dpath.sv
module esdate_dpath (
   input  logic                   clock,
   input  logic                   reset,
   input  esdate_pkg::cmd_type    cmd,
   input  logic [31:0]            req_epoch_seconds,
   output esdate_pkg::status_type status,
   output logic [11:0]            rsp_year,
   output logic [3:0]             rsp_month,
   output logic [4:0]             rsp_day,
   output logic [4:0]             rsp_hour,
   output logic [5:0]             rsp_minute,
   output logic [5:0]             rsp_second
);

   logic [31:0] rest_ff,   rest_in;
   logic [11:0] year_ff,   year_in;
   logic [3:0]  month_ff,  month_in;
   logic [4:0]  day_ff,    day_in;
   logic [4:0]  hour_ff,   hour_in;
   logic [5:0]  minute_ff, minute_in;
   logic [5:0]  second_ff, second_in;

   logic        leap;
   logic [31:0] span;
   logic [21:0] msecs;
   logic [29:0] day_prod;
   logic [25:0] hour_prod;
   logic [26:0] min_prod;
   logic [16:0] day_rem;
   logic [11:0] hour_rem;
   logic [5:0]  sec_rem;

   always_comb begin
      leap  = (year_ff[1:0] == 2'b00);
      span  = leap ? esdate_pkg::SecsLeapYear : esdate_pkg::SecsCommonYear;
      msecs = esdate_pkg::month_secs(leap, month_ff);

      status.year_done  = (rest_ff < span);
      status.month_done = (month_ff == esdate_pkg::LastMonth) || (rest_ff < 32'(msecs));

      day_prod  = 30'(rest_ff[21:7]) * 30'(esdate_pkg::DayRecip);
      hour_prod = 26'(rest_ff[16:4]) * 26'(esdate_pkg::HourRecip);
      min_prod  = 27'(rest_ff[11:0]) * 27'(esdate_pkg::MinRecip);

      day_rem  = 17'(rest_ff[21:0] - 22'(day_ff) * 22'(esdate_pkg::SecsPerDay));
      hour_rem = 12'(rest_ff[16:0] - 17'(hour_ff) * 17'(esdate_pkg::SecsPerHour));
      sec_rem  = 6'(rest_ff[11:0] - 12'(minute_ff) * 12'(esdate_pkg::SecsPerMinute));
   end

   always_comb begin
      rest_in   = rest_ff;
      year_in   = year_ff;
      month_in  = month_ff;
      day_in    = day_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      second_in = second_ff;
      if (cmd.load) begin
         rest_in  = req_epoch_seconds;
         year_in  = esdate_pkg::FirstYear;
         month_in = esdate_pkg::FirstMonth;
      end
      if (cmd.year_step) begin
         rest_in = rest_ff - span;
         year_in = year_ff + 12'd1;
      end
      if (cmd.month_step) begin
         rest_in  = rest_ff - 32'(msecs);
         month_in = month_ff + 4'd1;
      end
      if (cmd.day_q) begin
         day_in = day_prod[28:24];
      end
      if (cmd.day_r) begin
         rest_in = 32'(day_rem);
         day_in  = day_ff + 5'd1;
      end
      if (cmd.hour_q) begin
         hour_in = hour_prod[24:20];
      end
      if (cmd.hour_r) begin
         rest_in = 32'(hour_rem);
      end
      if (cmd.min_q) begin
         minute_in = min_prod[25:20];
      end
      if (cmd.min_r) begin
         second_in = sec_rem;
      end
   end

   always_ff @(posedge clock) begin
      rest_ff   <= rest_in;
      year_ff   <= year_in;
      month_ff  <= month_in;
      day_ff    <= day_in;
      hour_ff   <= hour_in;
      minute_ff <= minute_in;
      second_ff <= second_in;
   end

   assign rsp_year   = year_ff;
   assign rsp_month  = month_ff;
   assign rsp_day    = day_ff;
   assign rsp_hour   = hour_ff;
   assign rsp_minute = minute_ff;
   assign rsp_second = second_ff;

   a_month_range: assert property (@(posedge clock) disable iff (reset)
      cmd.month_step |-> (month_ff < esdate_pkg::LastMonth))
      else $error("month search ran past december");

   a_day_rem: assert property (@(posedge clock) disable iff (reset)
      cmd.day_r |=> (rest_ff < 32'(esdate_pkg::SecsPerDay)) && (day_ff != 5'd0))
      else $error("day quotient off");

   a_hour_rem: assert property (@(posedge clock) disable iff (reset)
      cmd.hour_r |=> (rest_ff < 32'(esdate_pkg::SecsPerHour)) && (hour_ff < 5'd24))
      else $error("hour quotient off");

   a_min_rem: assert property (@(posedge clock) disable iff (reset)
      cmd.min_r |=> (minute_ff < 6'd60) && (second_ff < 6'd60))
      else $error("minute quotient off");

endmodule
